>>> design/pcrg_pkg.sv
package pcrg_pkg;

    // Field widths
    localparam int COMP_W  = 20;          // one packed Q8.12 component
    localparam int CFG_W   = 3 * COMP_W;  // one packed xyz register
    localparam int DIM_W   = 13;          // image size register
    localparam int PIX_W   = 12;          // pixel coordinate
    localparam int HALF_W  = 15;          // pixel offset in half-pixel units
    localparam int DIR_W   = 16;          // Q1.14 direction component
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int PROD_W  = COMP_W + HALF_W;   // step times half-pixel offset
    localparam int A2_W    = PROD_W + 2;        // 2A, signed
    localparam int ABS_W   = A2_W - 1;          // |2A|
    localparam int POS_W   = 6;                 // leading one position of |2A|
    localparam int MAG_W   = 24;                // normalized magnitude
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int QUO_W   = 15;
    localparam int REM_W   = MAG_W + 16;
    localparam int DIR_FRAC = 14;

    localparam int DIR_ONE = 16384;
    localparam int MAX_DIM = 4096;
    localparam int DIM_RESET_W = 640;
    localparam int DIM_RESET_H = 480;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN  = 3'd0,
        CFG_FORWARD = 3'd1,
        CFG_RIGHT   = 3'd2,
        CFG_UP      = 3'd3,
        CFG_WIDTH   = 3'd4,
        CFG_HEIGHT  = 3'd5
    } t_cfg_reg;

    // Data that rides along with a ray through the sqrt and divide stages
    typedef struct packed {
        logic                         zero;
        logic [2:0]                   neg;
        logic [2:0][MAG_W-1:0]        mag;
        logic [2:0][COMP_W-1:0]       start;
    } t_side;

endpackage

>>> design/pcrg_front.sv
module pcrg_front
    import pcrg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [PIX_W-1:0]    i_pixel_x,
    input  logic [PIX_W-1:0]    i_pixel_y,
    input  logic [CFG_W-1:0]    i_origin,
    input  logic [CFG_W-1:0]    i_forward,
    input  logic [CFG_W-1:0]    i_right,
    input  logic [CFG_W-1:0]    i_up,
    input  logic [DIM_W-1:0]    i_width,
    input  logic [DIM_W-1:0]    i_height,
    output logic                o_valid,
    output t_side               o_side,
    output logic [SUM_W-1:0]    o_sum
);

    logic                     r1_v;
    logic signed [HALF_W-1:0] r1_hx, r1_hy;
    logic signed [HALF_W-1:0] n_hx, n_hy;

    logic                     r2_v;
    logic signed [PROD_W-1:0] r2_pr [3];
    logic signed [PROD_W-1:0] r2_pu [3];

    logic                     r3_v;
    logic signed [A2_W-1:0]   r3_a2 [3];

    logic                     r4_v;
    logic [2:0][COMP_W-1:0]   r4_start;
    logic [2:0]               r4_neg;
    logic [ABS_W-1:0]         r4_mag [3];
    logic [ABS_W-1:0]         r4_m;
    logic [2:0][COMP_W-1:0]   n_start;
    logic [2:0]               n_neg;
    logic [ABS_W-1:0]         n_mag [3];
    logic [ABS_W-1:0]         n_m01, n_m;

    logic                     r5_v;
    logic [POS_W-1:0]         r5_p;
    logic [ABS_W-1:0]         r5_mag [3];
    t_side                    r5_side;
    logic [POS_W-1:0]         n_p;

    logic                     r6_v;
    t_side                    r6_side;
    logic [2:0][MAG_W-1:0]    n_nm;

    logic                     r7_v;
    t_side                    r7_side;
    logic [SQ_W-1:0]          r7_sq [3];

    logic                     r8_v;
    t_side                    r8_side;
    logic [SUM_W-1:0]         r8_sum;

    // Valid bits of all front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    // Pixel offsets in half-pixel units: 2x+1-W and H-1-2y
    always_comb begin
        n_hx = {2'b00, i_pixel_x, 1'b1} - HALF_W'(i_width);
        n_hy = HALF_W'(i_height) - HALF_W'(1) - {2'b00, i_pixel_y, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r1_hx <= n_hx;
        r1_hy <= n_hy;
    end

    // Scale the step vectors by the offsets
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r2_pr[k] <= $signed(i_right[k*COMP_W +: COMP_W]) * r1_hx;
            r2_pu[k] <= $signed(i_up[k*COMP_W +: COMP_W]) * r1_hy;
        end
    end

    // Sum into 2A
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_a2[k] <= (A2_W'($signed(i_forward[k*COMP_W +: COMP_W])) <<< 1)
                        + A2_W'(r2_pr[k]) + A2_W'(r2_pu[k]);
        end
    end

    // Origin with round half up and saturation; magnitudes and their maximum
    always_comb begin
        logic signed [A2_W:0] t;
        logic signed [A2_W:0] s;
        for (int k = 0; k < 3; k++) begin
            t = ((A2_W+1)'($signed(i_origin[k*COMP_W +: COMP_W])) <<< 1)
                + (A2_W+1)'(r3_a2[k]);
            s = (t + (A2_W+1)'(1)) >>> 1;
            if (s > (A2_W+1)'(524287)) begin
                n_start[k] = COMP_W'(524287);
            end else if (s < -(A2_W+1)'(524288)) begin
                n_start[k] = COMP_W'(524288);
            end else begin
                n_start[k] = COMP_W'(s);
            end
            n_neg[k] = r3_a2[k][A2_W-1];
            n_mag[k] = n_neg[k] ? ABS_W'(-r3_a2[k]) : ABS_W'(r3_a2[k]);
        end
        n_m01 = (n_mag[0] > n_mag[1]) ? n_mag[0] : n_mag[1];
        n_m   = (n_m01 > n_mag[2]) ? n_m01 : n_mag[2];
    end

    always_ff @(posedge i_clk) begin
        r4_start <= n_start;
        r4_neg   <= n_neg;
        r4_mag   <= n_mag;
        r4_m     <= n_m;
    end

    // Find the leading one of the largest magnitude
    always_comb begin
        n_p = '0;
        for (int b = 0; b < ABS_W; b++) begin
            if (r4_m[b]) n_p = POS_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        r5_p          <= n_p;
        r5_mag        <= r4_mag;
        r5_side.zero  <= (r4_m == '0);
        r5_side.neg   <= r4_neg;
        r5_side.mag   <= '0;
        r5_side.start <= r4_start;
    end

    // Shift all three so the largest lies in [2^23, 2^24)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r5_p >= POS_W'(MAG_W - 1)) begin
                n_nm[k] = MAG_W'(r5_mag[k] >> (r5_p - POS_W'(MAG_W - 1)));
            end else begin
                n_nm[k] = MAG_W'(r5_mag[k] << (POS_W'(MAG_W - 1) - r5_p));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r6_side.zero  <= r5_side.zero;
        r6_side.neg   <= r5_side.neg;
        r6_side.mag   <= n_nm;
        r6_side.start <= r5_side.start;
    end

    // Square each component
    always_ff @(posedge i_clk) begin
        r7_side <= r6_side;
        for (int k = 0; k < 3; k++) begin
            r7_sq[k] <= SQ_W'(r6_side.mag[k]) * SQ_W'(r6_side.mag[k]);
        end
    end

    // Sum of squares
    always_ff @(posedge i_clk) begin
        r8_side <= r7_side;
        r8_sum  <= SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]);
    end

    assign o_valid = r8_v;
    assign o_side  = r8_side;
    assign o_sum   = r8_sum;

endmodule

>>> design/pcrg_sqrt.sv
module pcrg_sqrt
    import pcrg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_side               i_side,
    input  logic [SUM_W-1:0]    i_sum,
    output logic                o_valid,
    output t_side               o_side,
    output logic [ROOT_W-1:0]   o_root
);

    // One root bit per stage, most significant first
    logic                r_v    [ROOT_W];
    t_side               r_side [ROOT_W];
    logic [SUM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];

    logic                a_v    [ROOT_W];
    t_side               a_side [ROOT_W];
    logic [SUM_W-1:0]    a_rem  [ROOT_W];
    logic [ROOT_W-1:0]   a_root [ROOT_W];

    // Stage inputs: the port for the first stage, the previous stage after that
    always_comb begin
        a_v[0]    = i_valid;
        a_side[0] = i_side;
        a_rem[0]  = i_sum;
        a_root[0] = '0;
        for (int j = 1; j < ROOT_W; j++) begin
            a_v[j]    = r_v[j-1];
            a_side[j] = r_side[j-1];
            a_rem[j]  = r_rem[j-1];
            a_root[j] = r_root[j-1];
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - j;

        logic [SUM_W-1:0]  n_trial;
        logic [SUM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        // Try setting this bit: (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
        always_comb begin
            n_trial = (SUM_W'(a_root[j]) << (BIT + 1)) | (SUM_W'(1) << (2 * BIT));
            if (a_rem[j] >= n_trial) begin
                n_rem  = a_rem[j] - n_trial;
                n_root = a_root[j] | (ROOT_W'(1) << BIT);
            end else begin
                n_rem  = a_rem[j];
                n_root = a_root[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= a_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[j] <= a_side[j];
            r_rem[j]  <= n_rem;
            r_root[j] <= n_root;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

>>> design/pcrg_div.sv
module pcrg_div
    import pcrg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_side                  i_side,
    input  logic [ROOT_W-1:0]      i_root,
    output logic                   o_valid,
    output t_side                  o_side,
    output logic [2:0][QUO_W-1:0]  o_quo
);

    // Three lanes of restoring division, one quotient bit per stage
    logic                   r_v    [QUO_W];
    t_side                  r_side [QUO_W];
    logic [ROOT_W-1:0]      r_den  [QUO_W];
    logic [REM_W-1:0]       r_rem  [QUO_W][3];
    logic [2:0][QUO_W-1:0]  r_quo  [QUO_W];

    logic                   a_v    [QUO_W];
    t_side                  a_side [QUO_W];
    logic [ROOT_W-1:0]      a_den  [QUO_W];
    logic [REM_W-1:0]       a_rem  [QUO_W][3];
    logic [2:0][QUO_W-1:0]  a_quo  [QUO_W];

    // First stage takes mag*2^14 + n/2 as the dividend
    always_comb begin
        a_v[0]    = i_valid;
        a_side[0] = i_side;
        a_den[0]  = i_root;
        a_quo[0]  = '0;
        for (int k = 0; k < 3; k++) begin
            a_rem[0][k] = (REM_W'(i_side.mag[k]) << DIR_FRAC) + REM_W'(i_root >> 1);
        end
        for (int j = 1; j < QUO_W; j++) begin
            a_v[j]    = r_v[j-1];
            a_side[j] = r_side[j-1];
            a_den[j]  = r_den[j-1];
            a_quo[j]  = r_quo[j-1];
            for (int k = 0; k < 3; k++) begin
                a_rem[j][k] = r_rem[j-1][k];
            end
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int BIT = QUO_W - 1 - j;

        logic [REM_W-1:0]      n_sub;
        logic [REM_W-1:0]      n_rem [3];
        logic [2:0][QUO_W-1:0] n_quo;

        // Subtract the shifted divisor where it fits
        always_comb begin
            n_sub = REM_W'(a_den[j]) << BIT;
            n_quo = a_quo[j];
            for (int k = 0; k < 3; k++) begin
                if (a_rem[j][k] >= n_sub) begin
                    n_rem[k]      = a_rem[j][k] - n_sub;
                    n_quo[k][BIT] = 1'b1;
                end else begin
                    n_rem[k]      = a_rem[j][k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= a_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[j] <= a_side[j];
            r_den[j]  <= a_den[j];
            r_quo[j]  <= n_quo;
            for (int k = 0; k < 3; k++) begin
                r_rem[j][k] <= n_rem[k];
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];

endmodule

>>> design/pinhole_camera_ray_generator.sv
// Pinhole camera primary ray generator.
//
// Pulse start with a pixel (i_pixel_x, i_pixel_y); the pixel is taken at the
// rising edge where start is high and busy is low. busy is low except while
// reset is held, so a new pixel can be given on every cycle.
// When a pixel that was taken leaves the end of the pipeline, o_valid is
// high for one cycle with the ray origin (o_start_*, Q8.12, saturated) and the
// unit direction (o_dir_*, Q1.14). Rays leave in pixel order, one per cycle at
// full rate. The pipeline holds 8 stages of offset, multiply, normalize and sum
// of squares, 25 stages of square root (one root bit each), 15 stages of
// division (one quotient bit each, three lanes) and the output register.
// There is no back pressure: the receiver must take every result.
// The camera registers are written through i_cfg_valid / o_cfg_ready with a
// register index and data; o_cfg_ready is always high. Write them only while
// no ray is in flight. Reset clears the camera vectors to zero, sets the image
// to 640 by 480 and drops every ray in flight.
module pinhole_camera_ray_generator
    import pcrg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [PIX_W-1:0]        i_pixel_x,
    input  logic [PIX_W-1:0]        i_pixel_y,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [COMP_W-1:0] o_start_x,
    output logic signed [COMP_W-1:0] o_start_y,
    output logic signed [COMP_W-1:0] o_start_z,
    output logic signed [DIR_W-1:0] o_dir_x,
    output logic signed [DIR_W-1:0] o_dir_y,
    output logic signed [DIR_W-1:0] o_dir_z
);

    logic [CFG_W-1:0]   r_origin, r_forward, r_right, r_up;
    logic [DIM_W-1:0]   r_width, r_height;
    logic [DIM_W-1:0]   n_dim;

    logic               front_valid;
    t_side              front_side;
    logic [SUM_W-1:0]   front_sum;

    logic               sqrt_valid;
    t_side              sqrt_side;
    logic [ROOT_W-1:0]  sqrt_root;

    logic               div_valid;
    t_side              div_side;
    logic [2:0][QUO_W-1:0] div_quo;

    logic               r_out_v;
    logic [2:0][COMP_W-1:0] r_start;
    logic [2:0][DIR_W-1:0]  r_dir;
    logic [2:0][DIR_W-1:0]  n_dir;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; image sizes saturate at the largest size
    always_comb begin
        n_dim = i_cfg_data[DIM_W-1:0];
        if (n_dim > DIM_W'(MAX_DIM)) n_dim = DIM_W'(MAX_DIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= '0;
            r_forward <= '0;
            r_right   <= '0;
            r_up      <= '0;
            r_width   <= DIM_W'(DIM_RESET_W);
            r_height  <= DIM_W'(DIM_RESET_H);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ORIGIN:  r_origin  <= i_cfg_data;
                CFG_FORWARD: r_forward <= i_cfg_data;
                CFG_RIGHT:   r_right   <= i_cfg_data;
                CFG_UP:      r_up      <= i_cfg_data;
                CFG_WIDTH:   r_width   <= n_dim;
                CFG_HEIGHT:  r_height  <= n_dim;
                default: ;
            endcase
        end
    end

    pcrg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_origin  (r_origin),
        .i_forward (r_forward),
        .i_right   (r_right),
        .i_up      (r_up),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_valid   (front_valid),
        .o_side    (front_side),
        .o_sum     (front_sum)
    );

    pcrg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_side  (front_side),
        .i_sum   (front_sum),
        .o_valid (sqrt_valid),
        .o_side  (sqrt_side),
        .o_root  (sqrt_root)
    );

    pcrg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_valid),
        .i_side  (sqrt_side),
        .i_root  (sqrt_root),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_quo   (div_quo)
    );

    // Clamp to one, apply the sign, zero the direction of a null offset
    always_comb begin
        logic [QUO_W-1:0] q;
        for (int k = 0; k < 3; k++) begin
            q = div_quo[k];
            if (q > QUO_W'(DIR_ONE)) q = QUO_W'(DIR_ONE);
            if (div_side.zero) begin
                n_dir[k] = '0;
            end else if (div_side.neg[k]) begin
                n_dir[k] = -DIR_W'(q);
            end else begin
                n_dir[k] = DIR_W'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= div_side.start;
        r_dir   <= n_dir;
    end

    assign o_valid   = r_out_v;
    assign o_start_x = r_start[0];
    assign o_start_y = r_start[1];
    assign o_start_z = r_start[2];
    assign o_dir_x   = r_dir[0];
    assign o_dir_y   = r_dir[1];
    assign o_dir_z   = r_dir[2];

    // Direction components stay within plus or minus one
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_x <= DIR_W'(DIR_ONE) && o_dir_x >= -DIR_W'(DIR_ONE)
                  && o_dir_y <= DIR_W'(DIR_ONE) && o_dir_y >= -DIR_W'(DIR_ONE)
                  && o_dir_z <= DIR_W'(DIR_ONE) && o_dir_z >= -DIR_W'(DIR_ONE)))
        else $error("ray direction component out of range");

    // Image sizes never exceed the largest size
    a_dim_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_valid) |-> (r_width <= DIM_W'(MAX_DIM) && r_height <= DIM_W'(MAX_DIM)))
        else $error("image size above limit");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pcrg_pkg::*;

    localparam int LATENCY   = 49;
    localparam int MAX_CYCLES = 2000000;

    typedef struct {
        logic signed [COMP_W-1:0] sx, sy, sz;
        logic signed [DIR_W-1:0]  dx, dy, dz;
    } t_ray;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [PIX_W-1:0]     i_pixel_x;
    logic [PIX_W-1:0]     i_pixel_y;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic signed [COMP_W-1:0] o_start_x, o_start_y, o_start_z;
    logic signed [DIR_W-1:0]  o_dir_x, o_dir_y, o_dir_z;

    // camera registers as the predictor sees them
    logic [CFG_W-1:0] cam_origin, cam_forward, cam_right, cam_up;
    logic [DIM_W-1:0] img_w, img_h;

    t_ray   ray_queue[$];
    int     errors;
    int     cycles;
    int     idle_pct;

    pinhole_camera_ray_generator u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint comp(logic [CFG_W-1:0] packed_v, int k);
        logic signed [COMP_W-1:0] c;
        c = packed_v[k*COMP_W +: COMP_W];
        return longint'(c);
    endfunction

    function automatic longint floor_half(longint t);
        longint u;
        longint q;
        u = t + 1;
        q = u / 2;
        if (u < 0 && q * 2 != u) q--;
        return q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // compute the ray for one pixel
    function automatic t_ray trace_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        t_ray r;
        longint hx, hy, s;
        longint off[3];
        longint unsigned mag[3];
        longint unsigned m, sq, n, q;
        longint st[3];
        longint dr[3];
        hx = 2 * longint'(px) + 1 - longint'(img_w);
        hy = longint'(img_h) - 1 - 2 * longint'(py);
        m = 0;
        for (int k = 0; k < 3; k++) begin
            off[k] = 2 * comp(cam_forward, k) + comp(cam_right, k) * hx
                   + comp(cam_up, k) * hy;
            s = floor_half(2 * comp(cam_origin, k) + off[k]);
            if (s > 524287) s = 524287;
            if (s < -524288) s = -524288;
            st[k] = s;
            mag[k] = off[k] < 0 ? -off[k] : off[k];
            if (mag[k] > m) m = mag[k];
        end
        dr = '{0, 0, 0};
        if (m != 0) begin
            while (m >= (64'd1 << 24)) begin
                m >>= 1;
                for (int k = 0; k < 3; k++) mag[k] >>= 1;
            end
            while (m < (64'd1 << 23)) begin
                m <<= 1;
                for (int k = 0; k < 3; k++) mag[k] <<= 1;
            end
            sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            n = int_sqrt(sq);
            for (int k = 0; k < 3; k++) begin
                q = ((mag[k] << 14) + n / 2) / n;
                if (q > DIR_ONE) q = DIR_ONE;
                dr[k] = off[k] < 0 ? -longint'(q) : longint'(q);
            end
        end
        r.sx = COMP_W'(st[0]); r.sy = COMP_W'(st[1]); r.sz = COMP_W'(st[2]);
        r.dx = DIR_W'(dr[0]); r.dy = DIR_W'(dr[1]); r.dz = DIR_W'(dr[2]);
        return r;
    endfunction

    // compare each ray with the oldest prediction
    always @(posedge i_clk) begin
        t_ray e;
        if (i_rst_n && o_valid) begin
            if (ray_queue.size() == 0) begin
                $display("%0t: unexpected ray start %0d %0d %0d", $time,
                         o_start_x, o_start_y, o_start_z);
                errors++;
            end else begin
                e = ray_queue.pop_front();
                if (o_start_x !== e.sx) begin
                    $display("%0t: start_x exp %0d got %0d", $time, e.sx, o_start_x);
                    errors++;
                end
                if (o_start_y !== e.sy) begin
                    $display("%0t: start_y exp %0d got %0d", $time, e.sy, o_start_y);
                    errors++;
                end
                if (o_start_z !== e.sz) begin
                    $display("%0t: start_z exp %0d got %0d", $time, e.sz, o_start_z);
                    errors++;
                end
                if (o_dir_x !== e.dx) begin
                    $display("%0t: dir_x exp %0d got %0d", $time, e.dx, o_dir_x);
                    errors++;
                end
                if (o_dir_y !== e.dy) begin
                    $display("%0t: dir_y exp %0d got %0d", $time, e.dy, o_dir_y);
                    errors++;
                end
                if (o_dir_z !== e.dz) begin
                    $display("%0t: dir_z exp %0d got %0d", $time, e.dz, o_dir_z);
                    errors++;
                end
            end
        end
    end

    // send one pixel; start stays high across back-to-back transactions
    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ray_queue.push_back(trace_pixel(px, py));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (ray_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write one register; hold the shadow copy in step with it
    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
        logic [DIM_W-1:0] d;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        d = val[DIM_W-1:0];
        if (d > DIM_W'(MAX_DIM)) d = DIM_W'(MAX_DIM);
        case (idx)
            CFG_ORIGIN:  cam_origin = val;
            CFG_FORWARD: cam_forward = val;
            CFG_RIGHT:   cam_right = val;
            CFG_UP:      cam_up = val;
            CFG_WIDTH:   img_w = d;
            CFG_HEIGHT:  img_h = d;
            default: ;
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pack3(int x, int y, int z);
        return {z[COMP_W-1:0], y[COMP_W-1:0], x[COMP_W-1:0]};
    endfunction

    function automatic logic [CFG_W-1:0] rand_vec();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_W-1:0];
    endfunction

    // small-magnitude component so rays stay mostly in range
    function automatic logic [CFG_W-1:0] rand_small_vec(int lim);
        return pack3($urandom_range(2*lim) - lim, $urandom_range(2*lim) - lim,
                     $urandom_range(2*lim) - lim);
    endfunction

    task automatic test_reset_defaults();
        // all vectors zero: zero offset case, origin zero
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd319, 12'd239);
        send_pixel(12'hFFF, 12'hFFF);
        drain();
    endtask

    task automatic test_directed();
        write_reg(CFG_ORIGIN, pack3(4096, -8192, 100));
        write_reg(CFG_FORWARD, pack3(0, 0, -4096));
        write_reg(CFG_RIGHT, pack3(16, 0, 0));
        write_reg(CFG_UP, pack3(0, 16, 0));
        write_reg(CFG_WIDTH, CFG_W'(640));
        write_reg(CFG_HEIGHT, CFG_W'(480));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0, 12'hFFF);
        drain();
        // saturating origin, extreme vectors, oversized image
        write_reg(CFG_ORIGIN, pack3(524287, -524288, 524287));
        write_reg(CFG_FORWARD, pack3(524287, -524288, 0));
        write_reg(CFG_RIGHT, pack3(-524288, 524287, -524288));
        write_reg(CFG_UP, pack3(524287, 524287, -524288));
        write_reg(CFG_WIDTH, CFG_W'(13'h1FFF));
        write_reg(CFG_HEIGHT, CFG_W'(13'h1FFF));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd2048, 12'd2047);
        drain();
        // zero-width image of height one
        write_reg(CFG_WIDTH, CFG_W'(0));
        write_reg(CFG_HEIGHT, CFG_W'(1));
        write_reg(CFG_FORWARD, '0);
        write_reg(CFG_RIGHT, pack3(1, 0, 0));
        write_reg(CFG_UP, '0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        drain();
        // offset exactly zero at image center
        write_reg(CFG_WIDTH, CFG_W'(1));
        send_pixel(12'd0, 12'd0);
        drain();
        // ignored write to an unused index
        write_reg(t_cfg_reg'(3'd7), {CFG_W{1'b1}});
        write_reg(t_cfg_reg'(3'd6), '0);
        send_pixel(12'd5, 12'd5);
        drain();
    endtask

    task automatic test_random(int n_items, int pct);
        idle_pct = pct;
        for (int ph = 0; ph < 4; ph++) begin
            if ($urandom_range(1)) begin
                write_reg(CFG_ORIGIN, rand_vec());
                write_reg(CFG_FORWARD, rand_vec());
                write_reg(CFG_RIGHT, rand_vec());
                write_reg(CFG_UP, rand_vec());
            end else begin
                write_reg(CFG_ORIGIN, rand_small_vec(100000));
                write_reg(CFG_FORWARD, rand_small_vec(20000));
                write_reg(CFG_RIGHT, rand_small_vec(64));
                write_reg(CFG_UP, rand_small_vec(64));
            end
            write_reg(CFG_WIDTH, CFG_W'($urandom_range(1, 4096)));
            write_reg(CFG_HEIGHT, CFG_W'($urandom_range(1, 4096)));
            for (int i = 0; i < n_items / 4; i++) begin
                if ($urandom_range(3) == 0)
                    send_pixel(PIX_W'($urandom), PIX_W'($urandom));
                else
                    send_pixel(PIX_W'($urandom_range(img_w)),
                               PIX_W'($urandom_range(img_h)));
            end
            drain();
        end
        idle_pct = 0;
    endtask

    initial begin
        errors      = 0;
        cycles      = 0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_pixel_x   = '0;
        i_pixel_y   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cam_origin  = '0;
        cam_forward = '0;
        cam_right   = '0;
        cam_up      = '0;
        img_w       = DIM_W'(DIM_RESET_W);
        img_h       = DIM_W'(DIM_RESET_H);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed();
        test_random(200, 0);
        test_random(200, 63);
        test_random(200, 0);
        test_random(200, 35);

        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && ray_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
design/pcrg_pkg.sv
design/pcrg_front.sv
design/pcrg_sqrt.sv
design/pcrg_div.sv
design/pinhole_camera_ray_generator.sv
test/testbench.sv
